@@ rtl/mcbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbc_pkg: shared types and constants of the multi-click button counter
// Register indexes, configuration and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcbc_pkg;

  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned TOTAL_BITS   = 8;

  localparam logic [CFG_BITS-1:0] ACTIVE_MIN_RST   = 16'd5;
  localparam logic [CFG_BITS-1:0] ACTIVE_MAX_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] INACTIVE_MIN_RST = 16'd4;
  localparam logic [CFG_BITS-1:0] INACTIVE_MAX_RST = 16'd18;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ACTIVE_MIN   = 8'd0,
    REG_ACTIVE_MAX   = 8'd1,
    REG_INACTIVE_MIN = 8'd2,
    REG_INACTIVE_MAX = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] active_min;
    logic [CFG_BITS-1:0] active_max;
    logic [CFG_BITS-1:0] inactive_min;
    logic [CFG_BITS-1:0] inactive_max;
  } cfg_t;

  typedef struct packed {
    logic                  burst_done;
    logic [TOTAL_BITS-1:0] click_total;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_stat_t;

endpackage

`default_nettype wire

@@ rtl/mcbc_if.sv @@
// ----------------------------------------------------------------------------
// mcbc_if: channel interfaces of the multi-click button counter
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mcbc_in_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink   (input valid, input pressed, output ready);
endinterface

interface mcbc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              burst_done;
  logic [mcbc_pkg::TOTAL_BITS-1:0]   click_total;

  modport source (output valid, output burst_done, output click_total, input ready);
  modport sink   (input valid, input burst_done, input click_total, output ready);
endinterface

interface mcbc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mcbc_pkg::CFG_IDX_BITS-1:0] index;
  logic [mcbc_pkg::CFG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/mcbc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mcbc_cfg_regs: configuration registers
// Holds the press and release window limits written over the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcbc_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              wr_valid_i,
  input  wire logic [mcbc_pkg::CFG_IDX_BITS-1:0] wr_index_i,
  input  wire logic [mcbc_pkg::CFG_BITS-1:0]     wr_data_i,
  output      mcbc_pkg::cfg_t                    cfg_o
);

  mcbc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        mcbc_pkg::REG_ACTIVE_MIN:   cfg_d.active_min   = wr_data_i;
        mcbc_pkg::REG_ACTIVE_MAX:   cfg_d.active_max   = wr_data_i;
        mcbc_pkg::REG_INACTIVE_MIN: cfg_d.inactive_min = wr_data_i;
        mcbc_pkg::REG_INACTIVE_MAX: cfg_d.inactive_max = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_min   <= mcbc_pkg::ACTIVE_MIN_RST;
      cfg_q.active_max   <= mcbc_pkg::ACTIVE_MAX_RST;
      cfg_q.inactive_min <= mcbc_pkg::INACTIVE_MIN_RST;
      cfg_q.inactive_max <= mcbc_pkg::INACTIVE_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/mcbc_core.sv @@
// ----------------------------------------------------------------------------
// mcbc_core: run counters and click decision
// Updates the press/release runs and pending clicks once per accepted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcbc_core #(
  parameter int unsigned RUN_BITS   = 16,
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              pressed_i,
  input       mcbc_pkg::cfg_t    cfg_i,
  output      mcbc_pkg::result_t result_o
);

  localparam int unsigned CMP_BITS =
    (RUN_BITS > mcbc_pkg::CFG_BITS) ? RUN_BITS : mcbc_pkg::CFG_BITS;
  localparam int unsigned TOT_BITS =
    (COUNT_BITS > mcbc_pkg::TOTAL_BITS) ? COUNT_BITS : mcbc_pkg::TOTAL_BITS;
  localparam logic [TOT_BITS-1:0] TOTAL_TOP = TOT_BITS'((1 << mcbc_pkg::TOTAL_BITS) - 1);

  logic [RUN_BITS-1:0]   press_run_q, press_run_d;
  logic [RUN_BITS-1:0]   release_run_q, release_run_d;
  logic [RUN_BITS-1:0]   last_press_q, last_press_d;
  logic [COUNT_BITS-1:0] pending_q, pending_d;
  logic                  taken_q, taken_d;

  logic [COUNT_BITS-1:0] pending_c;
  logic [CMP_BITS-1:0]   lpl_x, rr_x;
  logic                  click, done;
  logic [TOT_BITS-1:0]   pend_x;
  mcbc_pkg::result_t     result_d;

  always_comb begin
    press_run_d   = press_run_q;
    release_run_d = release_run_q;
    last_press_d  = last_press_q;
    taken_d       = taken_q;
    if (pressed_i) begin
      press_run_d   = (&press_run_q) ? press_run_q : press_run_q + 1'b1;
      release_run_d = '0;
      taken_d       = 1'b0;
    end else begin
      if (press_run_q != '0) begin
        last_press_d = press_run_q;
        press_run_d  = '0;
      end
      release_run_d = (&release_run_q) ? release_run_q : release_run_q + 1'b1;
    end

    lpl_x = CMP_BITS'(last_press_d);
    rr_x  = CMP_BITS'(release_run_d);
    click = (lpl_x >= CMP_BITS'(cfg_i.active_min)) &&
            (lpl_x <= CMP_BITS'(cfg_i.active_max)) &&
            (rr_x >= CMP_BITS'(cfg_i.inactive_min)) &&
            (rr_x <= CMP_BITS'(cfg_i.inactive_max)) && !taken_d;

    pending_c = pending_q;
    if (click) begin
      pending_c = (&pending_q) ? pending_q : pending_q + 1'b1;
      taken_d   = 1'b1;
    end

    done      = (rr_x > CMP_BITS'(cfg_i.inactive_max)) && (pending_c != '0);
    pend_x    = TOT_BITS'(pending_c);
    pending_d = done ? '0 : pending_c;

    result_d.burst_done  = done;
    result_d.click_total = '0;
    if (done) begin
      result_d.click_total = (pend_x > TOTAL_TOP) ? TOTAL_TOP[mcbc_pkg::TOTAL_BITS-1:0]
                                                  : pend_x[mcbc_pkg::TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_run_q   <= '0;
      release_run_q <= '0;
      last_press_q  <= '0;
      pending_q     <= '0;
      taken_q       <= 1'b0;
    end else if (accept_i) begin
      press_run_q   <= press_run_d;
      release_run_q <= release_run_d;
      last_press_q  <= last_press_d;
      pending_q     <= pending_d;
      taken_q       <= taken_d;
    end
  end

  assign result_o = result_d;

endmodule

`default_nettype wire

@@ rtl/mcbc_out_buf.sv @@
// ----------------------------------------------------------------------------
// mcbc_out_buf: result register with skid stage
// Holds result words so a new sample is taken while the sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcbc_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input       mcbc_pkg::result_t data_i,
  output      logic              ready_o,
  output      logic              valid_o,
  input  wire logic              pop_ready_i,
  output      mcbc_pkg::result_t data_o,
  output      mcbc_pkg::buf_stat_t stat_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  mcbc_pkg::result_t main_q, main_d;
  mcbc_pkg::result_t skid_q, skid_d;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (main_v_q && pop_ready_i) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        main_d = data_i;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (!main_v_q) begin
      if (push_i) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end
    end else if (push_i) begin
      skid_d   = data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o           = !skid_v_q;
  assign valid_o           = main_v_q;
  assign data_o            = main_q;
  assign stat_o.main_valid = main_v_q;
  assign stat_o.skid_valid = skid_v_q;

endmodule

`default_nettype wire

@@ rtl/multi_click_button_counter.sv @@
// ----------------------------------------------------------------------------
// multi_click_button_counter: counts click bursts from per-frame button words
// Result words are formed combinationally and held in the result or skid register.
// Throughput: one word per cycle while the skid stage is free; a full skid stalls input.
// Reset: runs, last press, pending clicks cleared; limits return to 5/50/4/18.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_click_button_counter #(
  parameter int unsigned RUN_BITS   = 16,
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcbc_in_if.sink     in_i,
  mcbc_out_if.source  out_o,
  mcbc_cfg_if.sink    cfg_i
);

  mcbc_pkg::cfg_t      cfg;
  mcbc_pkg::result_t   result;
  mcbc_pkg::result_t   out_word;
  mcbc_pkg::buf_stat_t buf_stat;
  logic                in_ready;
  logic                accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  mcbc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  mcbc_core #(
    .RUN_BITS   (RUN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .pressed_i (in_i.pressed),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  mcbc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (in_ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .data_o      (out_word),
    .stat_o      (buf_stat)
  );

  assign out_o.burst_done  = out_word.burst_done;
  assign out_o.click_total = out_word.click_total;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_stat.skid_valid |-> buf_stat.main_valid)
    else $error("skid stage holds a word while the result register is empty");

  a_total_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.burst_done) |-> (out_o.click_total == '0))
    else $error("click total nonzero without a finished burst");

  a_total_nonzero_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.burst_done) |-> (out_o.click_total != '0))
    else $error("finished burst reported with zero clicks");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> buf_stat.main_valid)
    else $error("accepted sample produced no result word");
`endif

endmodule

`default_nettype wire

@@ tb/sv/multi_click_button_counter_tb.sv @@
// ----------------------------------------------------------------------------
// multi_click_button_counter_tb: self-checking bench of the click counter
// Feeds button words through a valid/ready channel with random gaps and
// output stalls. It reprograms the press and release windows between
// phases, checking every result word against a cycle-free predictor or typed row.
// A short directed table comes first, then random click bursts under
// several window settings. Last comes a click flood that saturates the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_click_button_counter_tb;
  import mcbc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_WORDS    = 80;
  localparam int unsigned PLAN_ROWS      = 32;
  localparam int unsigned FLOOD_CLICKS   = 260;

  typedef struct {
    logic                is_reg;
    cfg_reg_e            idx;
    logic [CFG_BITS-1:0] data;
    logic                pressed;
    logic                typed;
    result_t             word;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic calm;
  logic    typed_use;
  result_t typed_word;

  mcbc_in_if  in_if ();
  mcbc_out_if out_if ();
  mcbc_cfg_if cfg_if ();

  multi_click_button_counter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t                limits;
  logic [15:0]         press_frames;
  logic [15:0]         release_frames;
  logic [15:0]         held_frames;
  logic [7:0]          burst_clicks;
  logic                gap_counted;
  result_t             burst_reports_q [$];
  result_t             predicted;
  result_t             oldest;
  int unsigned         mismatches;
  int unsigned         quiet_cycles;
  plan_row_t           plan [PLAN_ROWS];
  int unsigned         plan_len;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic result_t count_clicks(input logic pressed);
    result_t r;
    r = '0;
    if (pressed) begin
      press_frames   = bump16(press_frames);
      release_frames = '0;
      gap_counted    = 1'b0;
    end else begin
      if (press_frames != 0) begin
        held_frames  = press_frames;
        press_frames = '0;
      end
      release_frames = bump16(release_frames);
    end
    if (held_frames >= limits.active_min && held_frames <= limits.active_max &&
        release_frames >= limits.inactive_min &&
        release_frames <= limits.inactive_max && !gap_counted) begin
      burst_clicks = (burst_clicks == 8'hFF) ? burst_clicks : burst_clicks + 8'd1;
      gap_counted  = 1'b1;
    end
    if (release_frames > limits.inactive_max && burst_clicks != 0) begin
      r.burst_done  = 1'b1;
      r.click_total = burst_clicks;
      burst_clicks  = '0;
    end
    return r;
  endfunction

  function automatic plan_row_t smp(input logic p);
    plan_row_t r;
    r = '{1'b0, REG_ACTIVE_MIN, '0, p, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t smp_chk(input logic p, input logic done,
                                        input logic [7:0] total);
    plan_row_t r;
    r = '{1'b0, REG_ACTIVE_MIN, '0, p, 1'b1, '{done, total}};
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input cfg_reg_e idx, input logic [15:0] data);
    plan_row_t r;
    r = '{1'b1, idx, data, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic cfg_t rand_limits(input int unsigned phase);
    cfg_t c;
    int   amin;
    int   imin;
    if (phase == 0) begin
      c = '0;
    end else if (phase == 1) begin
      c = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFE};
    end else begin
      amin = $urandom_range(0, 4);
      imin = $urandom_range(0, 4);
      c.active_min   = 16'(amin);
      c.active_max   = ($urandom_range(0, 7) == 0 && amin > 0) ? 16'(amin - 1)
                                                               : 16'(amin + $urandom_range(0, 6));
      c.inactive_min = 16'(imin);
      c.inactive_max = 16'(imin + $urandom_range(0, 8));
    end
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_ACTIVE_MIN:   limits.active_min   = cfg_if.data;
          REG_ACTIVE_MAX:   limits.active_max   = cfg_if.data;
          REG_INACTIVE_MIN: limits.inactive_min = cfg_if.data;
          REG_INACTIVE_MAX: limits.inactive_max = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predicted = count_clicks(in_if.pressed);
        if (typed_use) begin
          predicted = typed_word;
        end
        burst_reports_q.push_back(predicted);
      end
      if (out_if.valid && out_if.ready) begin
        if (burst_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: expected none, got done=%0b total=%0d",
                   $time, out_if.burst_done, out_if.click_total);
        end else begin
          oldest = burst_reports_q.pop_front();
          if (out_if.burst_done !== oldest.burst_done ||
              out_if.click_total !== oldest.click_total) begin
            mismatches++;
            $display("%0t: result mismatch: expected done=%0b total=%0d, got done=%0b total=%0d",
                     $time, oldest.burst_done, oldest.click_total,
                     out_if.burst_done, out_if.click_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("** multi_click_button_counter: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(input logic p, input logic with_typed, input result_t word,
                           input bit drain);
    int unsigned gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) gap++;
    end
    if (gap > 0 || (drain && burst_reports_q.size() != 0)) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      while (drain && burst_reports_q.size() != 0) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.pressed <= p;
    typed_use     <= with_typed;
    typed_word    <= word;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_run(input logic p, input int unsigned n, inout int unsigned sent);
    repeat (n) begin
      send_word(p, 1'b0, '0, $urandom_range(0, 49) == 0);
      sent++;
    end
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (burst_reports_q.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input cfg_reg_e idx, input logic [CFG_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic load_limits(input cfg_t c);
    quiesce();
    reg_write(REG_ACTIVE_MIN, c.active_min);
    reg_write(REG_ACTIVE_MAX, c.active_max);
    reg_write(REG_INACTIVE_MIN, c.inactive_min);
    reg_write(REG_INACTIVE_MAX, c.inactive_max);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_bursts(input int unsigned budget);
    int unsigned sent;
    int          amin;
    int          amax;
    int          imin;
    int          imax;
    int          clicks;
    int          plen;
    int          rlen;
    int          lo;
    sent = 0;
    amin = int'(limits.active_min);
    amax = int'(limits.active_max);
    imin = int'(limits.inactive_min);
    imax = int'(limits.inactive_max);
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_run(1'($urandom_range(0, 1)), 1, sent);
      end else begin
        clicks = $urandom_range(1, 4);
        for (int j = 0; j < clicks; j++) begin
          lo = (amin == 0) ? 1 : amin;
          if (lo <= amax && $urandom_range(0, 4) != 0) begin
            plen = $urandom_range(lo, (amax < lo + 15) ? amax : lo + 15);
          end else begin
            plen = $urandom_range(1, 20);
          end
          lo = (imin == 0) ? 1 : imin;
          if (j == clicks - 1) begin
            rlen = (imax < 40) ? imax + 1 + $urandom_range(0, 3) : $urandom_range(1, 30);
          end else if (lo <= imax && $urandom_range(0, 4) != 0) begin
            rlen = $urandom_range(lo, (imax < lo + 15) ? imax : lo + 15);
          end else begin
            rlen = $urandom_range(1, 20);
          end
          send_run(1'b1, plen, sent);
          send_run(1'b0, rlen, sent);
        end
      end
    end
  endtask

  initial begin
    int unsigned sent;
    rst_n          = 1'b0;
    calm           = 1'b0;
    in_if.valid    = 1'b0;
    in_if.pressed  = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_ACTIVE_MIN;
    cfg_if.data    = '0;
    typed_use      = 1'b0;
    typed_word     = '0;
    limits         = '{ACTIVE_MIN_RST, ACTIVE_MAX_RST, INACTIVE_MIN_RST, INACTIVE_MAX_RST};
    press_frames   = '0;
    release_frames = '0;
    held_frames    = '0;
    burst_clicks   = '0;
    gap_counted    = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    sent           = 0;

    plan_len = 0;
    plan[plan_len++] = smp_chk(1'b0, 1'b0, 8'd0);
    plan[plan_len++] = smp_chk(1'b1, 1'b0, 8'd0);
    plan[plan_len++] = reg_wr(REG_ACTIVE_MIN, 16'd1);
    plan[plan_len++] = reg_wr(REG_ACTIVE_MAX, 16'd3);
    plan[plan_len++] = reg_wr(REG_INACTIVE_MIN, 16'd1);
    plan[plan_len++] = reg_wr(REG_INACTIVE_MAX, 16'd2);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp_chk(1'b0, 1'b1, 8'd1);
    // click while held: zero release window start, one click per held frame
    plan[plan_len++] = reg_wr(REG_INACTIVE_MIN, 16'd0);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp_chk(1'b0, 1'b1, 8'd2);
    // empty press window
    plan[plan_len++] = reg_wr(REG_ACTIVE_MIN, 16'd4);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp_chk(1'b0, 1'b0, 8'd0);
    // burst that never ends, then the tightest release limit
    plan[plan_len++] = reg_wr(REG_ACTIVE_MIN, 16'd1);
    plan[plan_len++] = reg_wr(REG_INACTIVE_MAX, 16'hFFFF);
    plan[plan_len++] = smp(1'b1);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = smp(1'b0);
    plan[plan_len++] = reg_wr(REG_INACTIVE_MAX, 16'd0);
    plan[plan_len++] = smp_chk(1'b0, 1'b1, 8'd1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < plan_len; i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) begin
          quiesce();
        end
        reg_write(plan[i].idx, plan[i].data);
        if (i + 1 >= plan_len || !plan[i+1].is_reg) begin
          cfg_if.valid <= 1'b0;
        end
      end else begin
        send_word(plan[i].pressed, plan[i].typed, plan[i].word, 1'b0);
      end
    end

    for (int unsigned k = 0; k < RANDOM_PHASES; k++) begin
      load_limits(rand_limits(k));
      random_bursts(PHASE_WORDS);
    end

    // overflow the click count, with no random gaps or output stalls
    load_limits('{16'd1, 16'd1, 16'd1, 16'd3});
    calm = 1'b1;
    repeat (FLOOD_CLICKS) begin
      send_run(1'b1, 1, sent);
      send_run(1'b0, 1, sent);
    end
    send_run(1'b0, 5, sent);
    calm = 1'b0;

    quiesce();
    repeat (4) @(posedge clk);
    if (burst_reports_q.size() != 0) begin
      mismatches++;
      $display("%0t: result words missing: expected %0d more, got none",
               $time, burst_reports_q.size());
    end
    if (mismatches == 0) begin
      $display("** multi_click_button_counter: PASSED **");
    end else begin
      $display("** multi_click_button_counter: FAILED **");
    end
    $finish;
  end

endmodule
